FILE: src/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types, action codes and saturation helpers for the complex unit
// ----------------------------------------------------------------------------
package cau_pkg;

	localparam int FRAC_BITS_DEF = 16;
	// quotient magnitude bits below the overflow bit
	localparam int QW = 33;
	// divider remainder width: 64-bit divisor shifted by up to QW places
	localparam int DW = 64 + QW;
	// one divider step per quotient bit, overflow bit included
	localparam int NSTEP = QW + 1;

	localparam logic [2:0] ACT_ADD  = 3'd0;
	localparam logic [2:0] ACT_SUB  = 3'd1;
	localparam logic [2:0] ACT_MUL  = 3'd2;
	localparam logic [2:0] ACT_DIV  = 3'd3;
	localparam logic [2:0] ACT_CONJ = 3'd4;

	localparam logic [31:0] WORD_MAX = 32'h7fff_ffff;
	localparam logic [31:0] WORD_MIN = 32'h8000_0000;
	localparam logic [QW-1:0] LIM_POS = QW'(64'h7fff_ffff);
	localparam logic [QW-1:0] LIM_NEG = QW'(64'h8000_0000);

	typedef struct packed {
		logic [31:0] val;
		logic        sat;
	} clip_t;

	// result of a beat outside the divider, or sign and flags of a divide
	typedef struct packed {
		logic        is_div;
		logic        dz;
		logic        neg_re;
		logic        neg_im;
		logic        sat;
		logic [31:0] res_re;
		logic [31:0] res_im;
	} side_t;

	typedef struct packed {
		logic [DW-1:0] rem_re;
		logic [DW-1:0] rem_im;
		logic [QW:0]   q_re;
		logic [QW:0]   q_im;
		logic [63:0]   den;
	} div_t;

	function automatic clip_t sat_pack(input logic neg, input logic ovf,
			input logic [QW-1:0] mag);
		clip_t r;
		r.sat = 1'b0;
		r.val = '0;
		if (neg) begin
			if (ovf || mag > LIM_NEG) begin
				r.sat = 1'b1;
				r.val = WORD_MIN;
			end else begin
				r.val = 32'd0 - mag[31:0];
			end
		end else begin
			if (ovf || mag > LIM_POS) begin
				r.sat = 1'b1;
				r.val = WORD_MAX;
			end else begin
				r.val = mag[31:0];
			end
		end
		return r;
	endfunction

	// clip a 33-bit signed sum
	function automatic clip_t sat_sum(input logic [32:0] v);
		logic [32:0] m;
		m = v[32] ? (33'd0 - v) : v;
		return sat_pack(v[32], 1'b0, QW'(m));
	endfunction

endpackage

FILE: src/cau_in_if.sv
// ----------------------------------------------------------------------------
// cau_in_if
// Operand channel: action code and two complex operands
// ----------------------------------------------------------------------------
interface cau_in_if;
	logic               valid;
	logic               ready;
	logic [2:0]         action;
	logic signed [31:0] a_re;
	logic signed [31:0] a_im;
	logic signed [31:0] b_re;
	logic signed [31:0] b_im;

	modport source(output valid, action, a_re, a_im, b_re, b_im, input ready);
	modport sink(input valid, action, a_re, a_im, b_re, b_im, output ready);
endinterface

FILE: src/cau_out_if.sv
// ----------------------------------------------------------------------------
// cau_out_if
// Result channel: complex result and status flags
// ----------------------------------------------------------------------------
interface cau_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] res_re;
	logic signed [31:0] res_im;
	logic               div_zero;
	logic               saturated;

	modport source(output valid, res_re, res_im, div_zero, saturated, input ready);
	modport sink(input valid, res_re, res_im, div_zero, saturated, output ready);
endinterface

FILE: src/cau_front.sv
// ----------------------------------------------------------------------------
// cau_front
// Operand register, products, sums and divisor, multiply result and
// divider set-up over four stages
// ----------------------------------------------------------------------------
module cau_front #(
	parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [2:0]         action,
	input  logic signed [31:0] a_re,
	input  logic signed [31:0] a_im,
	input  logic signed [31:0] b_re,
	input  logic signed [31:0] b_im,
	output logic               out_valid,
	output cau_pkg::side_t     out_side,
	output cau_pkg::div_t      out_div
);

	// stage 1: operands
	logic               v_s1;
	logic [2:0]         act_s1;
	logic signed [31:0] ar_s1, ai_s1, br_s1, bi_s1;

	// stage 2: products and simple results
	logic               v_s2;
	logic [2:0]         act_s2;
	logic signed [63:0] p_rr_s2, p_ii_s2, p_ri_s2, p_ir_s2, p_br_s2, p_bi_s2;
	cau_pkg::side_t     side_s2;

	// stage 3: sums and divisor
	logic               v_s3;
	logic [2:0]         act_s3;
	logic [64:0]        sum_re_s3, sum_im_s3;
	logic [63:0]        den_s3;
	cau_pkg::side_t     side_s3;

	// stage 4
	logic               v_s4;
	cau_pkg::side_t     side_s4;
	cau_pkg::div_t      div_s4;

	cau_pkg::side_t     side_d2, side_d4;
	cau_pkg::div_t      div_d4;
	cau_pkg::clip_t     c_re, c_im, m_re, m_im;
	logic [64:0]        sre_d, sim_d;
	logic [64:0]        mag_re, mag_im;
	logic [63:0]        sh_re, sh_im;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// simple results
	always_comb begin
		side_d2 = '0;
		c_re = '0;
		c_im = '0;
		case (act_s1)
			cau_pkg::ACT_ADD: begin
				c_re = cau_pkg::sat_sum({ar_s1[31], ar_s1} + {br_s1[31], br_s1});
				c_im = cau_pkg::sat_sum({ai_s1[31], ai_s1} + {bi_s1[31], bi_s1});
			end
			cau_pkg::ACT_SUB: begin
				c_re = cau_pkg::sat_sum({ar_s1[31], ar_s1} - {br_s1[31], br_s1});
				c_im = cau_pkg::sat_sum({ai_s1[31], ai_s1} - {bi_s1[31], bi_s1});
			end
			cau_pkg::ACT_CONJ: begin
				c_re = cau_pkg::sat_sum({ar_s1[31], ar_s1});
				c_im = cau_pkg::sat_sum(33'd0 - {ai_s1[31], ai_s1});
			end
			default: begin
				c_re = '0;
				c_im = '0;
			end
		endcase
		side_d2.is_div = (act_s1 == cau_pkg::ACT_DIV);
		side_d2.res_re = c_re.val;
		side_d2.res_im = c_im.val;
		side_d2.sat    = c_re.sat | c_im.sat;
	end

	always_comb begin
		if (act_s2 == cau_pkg::ACT_DIV) begin
			sre_d = {p_rr_s2[63], p_rr_s2} + {p_ii_s2[63], p_ii_s2};
			sim_d = {p_ir_s2[63], p_ir_s2} - {p_ri_s2[63], p_ri_s2};
		end else begin
			sre_d = {p_rr_s2[63], p_rr_s2} - {p_ii_s2[63], p_ii_s2};
			sim_d = {p_ri_s2[63], p_ri_s2} + {p_ir_s2[63], p_ir_s2};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			act_s1    <= action;
			ar_s1     <= a_re;
			ai_s1     <= a_im;
			br_s1     <= b_re;
			bi_s1     <= b_im;
			act_s2    <= act_s1;
			p_rr_s2   <= ar_s1 * br_s1;
			p_ii_s2   <= ai_s1 * bi_s1;
			p_ri_s2   <= ar_s1 * bi_s1;
			p_ir_s2   <= ai_s1 * br_s1;
			p_br_s2   <= br_s1 * br_s1;
			p_bi_s2   <= bi_s1 * bi_s1;
			side_s2   <= side_d2;
			act_s3    <= act_s2;
			sum_re_s3 <= sre_d;
			sum_im_s3 <= sim_d;
			den_s3    <= p_br_s2 + p_bi_s2;
			side_s3   <= side_s2;
			side_s4   <= side_d4;
			div_s4    <= div_d4;
		end
	end

	// sign and magnitude, multiply result, divider set-up
	always_comb begin
		mag_re = sum_re_s3[64] ? (65'd0 - sum_re_s3) : sum_re_s3;
		mag_im = sum_im_s3[64] ? (65'd0 - sum_im_s3) : sum_im_s3;
		sh_re  = mag_re[63:0] >> FRAC_BITS;
		sh_im  = mag_im[63:0] >> FRAC_BITS;
		m_re   = cau_pkg::sat_pack(sum_re_s3[64], |sh_re[63:cau_pkg::QW],
			sh_re[cau_pkg::QW-1:0]);
		m_im   = cau_pkg::sat_pack(sum_im_s3[64], |sh_im[63:cau_pkg::QW],
			sh_im[cau_pkg::QW-1:0]);
		side_d4 = side_s3;
		if (act_s3 == cau_pkg::ACT_MUL) begin
			side_d4.res_re = m_re.val;
			side_d4.res_im = m_im.val;
			side_d4.sat    = m_re.sat | m_im.sat;
		end
		if (act_s3 == cau_pkg::ACT_DIV) begin
			side_d4.dz     = (den_s3 == 64'd0);
			side_d4.neg_re = sum_re_s3[64];
			side_d4.neg_im = sum_im_s3[64];
		end
		div_d4.rem_re = cau_pkg::DW'(mag_re[63:0]) << FRAC_BITS;
		div_d4.rem_im = cau_pkg::DW'(mag_im[63:0]) << FRAC_BITS;
		div_d4.q_re   = '0;
		div_d4.q_im   = '0;
		div_d4.den    = den_s3;
	end

	assign out_valid = v_s4;
	assign out_side  = side_s4;
	assign out_div   = div_s4;

endmodule

FILE: src/cau_div_step.sv
// ----------------------------------------------------------------------------
// cau_div_step
// One restoring-division stage: one quotient bit for both result parts
// ----------------------------------------------------------------------------
module cau_div_step #(
	parameter int SHIFT = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  cau_pkg::side_t in_side,
	input  cau_pkg::div_t  in_div,
	output logic           out_valid,
	output cau_pkg::side_t out_side,
	output cau_pkg::div_t  out_div
);

	logic                    v_s1;
	cau_pkg::side_t          side_s1;
	cau_pkg::div_t           div_s1;
	cau_pkg::div_t           div_d;
	logic [cau_pkg::DW-1:0]  dsh;
	logic                    ge_re, ge_im;

	always_comb begin
		dsh   = cau_pkg::DW'(in_div.den) << SHIFT;
		ge_re = (in_div.rem_re >= dsh);
		ge_im = (in_div.rem_im >= dsh);
		div_d        = in_div;
		div_d.rem_re = ge_re ? (in_div.rem_re - dsh) : in_div.rem_re;
		div_d.rem_im = ge_im ? (in_div.rem_im - dsh) : in_div.rem_im;
		div_d.q_re   = {in_div.q_re[cau_pkg::QW-1:0], ge_re};
		div_d.q_im   = {in_div.q_im[cau_pkg::QW-1:0], ge_im};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= in_side;
			div_s1  <= div_d;
		end
	end

	assign out_valid = v_s1;
	assign out_side  = side_s1;
	assign out_div   = div_s1;

endmodule

FILE: src/cau_back.sv
// ----------------------------------------------------------------------------
// cau_back
// Quotient clipping, result select and output register
// ----------------------------------------------------------------------------
module cau_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  cau_pkg::side_t in_side,
	input  cau_pkg::div_t  in_div,
	cau_out_if.source      res
);

	logic           valid_q;
	logic [31:0]    re_q, im_q;
	logic           dz_q, sat_q;
	cau_pkg::clip_t q_re, q_im;
	logic [31:0]    re_d, im_d;
	logic           sat_d;

	always_comb begin
		q_re = cau_pkg::sat_pack(in_side.neg_re, in_div.q_re[cau_pkg::QW],
			in_div.q_re[cau_pkg::QW-1:0]);
		q_im = cau_pkg::sat_pack(in_side.neg_im, in_div.q_im[cau_pkg::QW],
			in_div.q_im[cau_pkg::QW-1:0]);
		if (!in_side.is_div) begin
			re_d  = in_side.res_re;
			im_d  = in_side.res_im;
			sat_d = in_side.sat;
		end else if (in_side.dz) begin
			re_d  = '0;
			im_d  = '0;
			sat_d = 1'b0;
		end else begin
			re_d  = q_re.val;
			im_d  = q_im.val;
			sat_d = q_re.sat | q_im.sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			re_q  <= re_d;
			im_q  <= im_d;
			dz_q  <= in_side.is_div & in_side.dz;
			sat_q <= sat_d;
		end
	end

	assign res.valid     = valid_q;
	assign res.res_re    = re_q;
	assign res.res_im    = im_q;
	assign res.div_zero  = dz_q;
	assign res.saturated = sat_q;

endmodule

FILE: src/complex_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Saturating Q16.16 complex add, subtract, multiply, divide and conjugate
// ----------------------------------------------------------------------------
// Fully pipelined: a new beat may enter every cycle unless the sink stalls,
// and every beat, whatever its action, passes four front stages for
// operands, products, sums and set-up, one restoring-division stage per
// quotient bit including the overflow bit, and the output register. The
// whole pipeline advances when the output register is empty or taken, so a
// stalled sink holds every beat in place. No state is kept between beats.
module complex_arithmetic_unit #(
	parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	cau_in_if.sink    op,
	cau_out_if.source res
);

	logic           en;
	logic           v_c [0:cau_pkg::NSTEP];
	cau_pkg::side_t side_c [0:cau_pkg::NSTEP];
	cau_pkg::div_t  div_c [0:cau_pkg::NSTEP];

	assign en       = !res.valid || res.ready;
	assign op.ready = en;

	cau_front #(
		.FRAC_BITS(FRAC_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (op.valid),
		.action    (op.action),
		.a_re      (op.a_re),
		.a_im      (op.a_im),
		.b_re      (op.b_re),
		.b_im      (op.b_im),
		.out_valid (v_c[0]),
		.out_side  (side_c[0]),
		.out_div   (div_c[0])
	);

	for (genvar gi = 0; gi < cau_pkg::NSTEP; gi++) begin : g_step
		cau_div_step #(
			.SHIFT(cau_pkg::NSTEP - 1 - gi)
		) u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (v_c[gi]),
			.in_side   (side_c[gi]),
			.in_div    (div_c[gi]),
			.out_valid (v_c[gi+1]),
			.out_side  (side_c[gi+1]),
			.out_div   (div_c[gi+1])
		);
	end

	cau_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_c[cau_pkg::NSTEP]),
		.in_side  (side_c[cau_pkg::NSTEP]),
		.in_div   (div_c[cau_pkg::NSTEP]),
		.res      (res)
	);

	a_dz_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.div_zero |->
			res.res_re == 32'sd0 && res.res_im == 32'sd0 && !res.saturated)
		else $error("zero divisor beat with nonzero result");

	a_sat_rail: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.saturated |->
			res.res_re == cau_pkg::WORD_MAX || res.res_re == cau_pkg::WORD_MIN ||
			res.res_im == cau_pkg::WORD_MAX || res.res_im == cau_pkg::WORD_MIN)
		else $error("saturated beat without a clipped part");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |=>
			res.valid && $stable(res.res_re) && $stable(res.res_im))
		else $error("pipeline moved under a stalled output");

endmodule
